FILE: hw/rtl/key_click_classifier_core_defines.svh
// Assertion macros shared by the key click classifier RTL.
`ifndef KEY_CLICK_CLASSIFIER_CORE_DEFINES_SVH
`define KEY_CLICK_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kcc_pkg.sv
// Shared types and constants of the key click classifier.
package kcc_pkg;

    localparam int KEY_W   = 4;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [COUNT_W-1:0] PRESS_SHIFT_TICK = 8'd2;
    localparam logic [COUNT_W-1:0] RELEASE_CLEAR_MIN = 8'd3;

    localparam logic [COUNT_W-1:0] SINGLE_DELAY_RESET = 8'd20;
    localparam logic [COUNT_W-1:0] LONG_DELAY_RESET   = 8'd100;

    typedef enum logic [KIND_W-1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } kcc_kind_t;

    typedef enum logic [ADDR_W-1:0] {
        ADDR_SINGLE_DELAY = 3'd0,
        ADDR_LONG_DELAY   = 3'd4
    } kcc_addr_t;

endpackage

FILE: hw/rtl/key_click_classifier_core.sv
// Key click classifier: one scan tick per item, single/double/long click detection.
//
// Each input item is one scan tick carrying the scanned key code (0 = released).
// The core keeps a saturating press counter, a saturating release counter and the
// codes of the last two presses, and reports at most one click per tick as
// (click_kind, click_key): 0 single, 1 double, 2 long. A double click on two
// different keys reports as a single click. The release counter comes out of
// reset saturated, so unless the single-click delay is 255 no click fires until
// a key is pressed. Throughput is one tick per clock: the counter update and
// click decision are combinational from the state registers into the result
// register or skid entry; that one-entry skid stage lets a tick be taken while
// a result waits downstream; s_ready drops only while the skid entry is occupied.
// Delays are set through the APB port: the single-click delay at 0x0, the
// long-click delay at 0x4; write them only while the core is idle.
module key_click_classifier_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // scan tick input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [kcc_pkg::KEY_W-1:0]   s_key,
    // click output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [kcc_pkg::KIND_W-1:0]  m_click_kind,
    output logic [kcc_pkg::KEY_W-1:0]   m_click_key,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [kcc_pkg::DATA_W-1:0]  pwdata,
    output logic [kcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kcc_pkg::*;
    `include "key_click_classifier_core_defines.svh"

    // configuration registers
    logic [COUNT_W-1:0] single_delay_reg;
    logic [COUNT_W-1:0] long_delay_reg;

    // click state
    logic [COUNT_W-1:0] press_ticks_reg, press_ticks_next;
    logic [COUNT_W-1:0] release_ticks_reg, release_ticks_next;
    logic [2*KEY_W-1:0] recent_keys_reg, recent_keys_next;

    // output register and skid entry
    logic               out_valid_reg;
    kcc_kind_t          out_kind_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic               skid_valid_reg;
    kcc_kind_t          skid_kind_reg;
    logic [KEY_W-1:0]   skid_key_reg;

    // per-tick decision
    logic               accept;
    logic               fire;
    kcc_kind_t          kind;
    logic [COUNT_W-1:0] after_single;
    logic [COUNT_W-1:0] after_long;
    logic               long_hit;
    logic               shift_hit;
    logic               double_hit;
    logic [COUNT_W-1:0] release_mid;
    logic [2*KEY_W-1:0] keys_shifted;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign s_ready      = !skid_valid_reg;
    assign accept       = s_valid && s_ready;
    assign m_valid      = out_valid_reg;
    assign m_click_kind = out_kind_reg;
    assign m_click_key  = out_key_reg;

    always_comb begin
        case (paddr)
            ADDR_SINGLE_DELAY: prdata = {{(DATA_W-COUNT_W){1'b0}}, single_delay_reg};
            ADDR_LONG_DELAY:   prdata = {{(DATA_W-COUNT_W){1'b0}}, long_delay_reg};
            default:           prdata = '0;
        endcase
    end

    // Delay plus one wraps in 8 bits, matching a register value of 255.
    assign after_single = single_delay_reg + 8'd1;
    assign after_long   = long_delay_reg + 8'd1;

    // A long hit reloads the release counter before the double check looks at it.
    assign long_hit     = (press_ticks_reg == long_delay_reg);
    assign shift_hit    = (press_ticks_reg == PRESS_SHIFT_TICK);
    assign release_mid  = long_hit ? after_single : release_ticks_reg;
    assign keys_shifted = {recent_keys_reg[KEY_W-1:0], s_key};
    assign double_hit   = shift_hit && (release_mid < single_delay_reg);

    always_comb begin
        press_ticks_next   = press_ticks_reg;
        release_ticks_next = release_ticks_reg;
        recent_keys_next   = recent_keys_reg;
        fire               = 1'b0;
        kind               = KIND_SINGLE;
        if (s_key == '0) begin
            // released tick: single click when the release delay is reached
            fire = (release_ticks_reg == single_delay_reg);
            if (release_ticks_reg > RELEASE_CLEAR_MIN) begin
                press_ticks_next = '0;
            end
            if (release_ticks_reg != COUNT_MAX) begin
                release_ticks_next = release_ticks_reg + 8'd1;
            end
        end else begin
            release_ticks_next = release_mid;
            if (long_hit) begin
                fire = 1'b1;
                kind = KIND_LONG;
            end
            if (shift_hit) begin
                recent_keys_next = keys_shifted;
            end
            if (double_hit) begin
                // second press came soon enough: double if the same key
                fire = 1'b1;
                kind = (keys_shifted[2*KEY_W-1:KEY_W] == keys_shifted[KEY_W-1:0])
                       ? KIND_DOUBLE : KIND_SINGLE;
                release_ticks_next = after_single;
                press_ticks_next   = after_long;
            end else begin
                if (shift_hit) begin
                    release_ticks_next = '0;
                end
                if (press_ticks_reg != COUNT_MAX) begin
                    press_ticks_next = press_ticks_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            single_delay_reg  <= SINGLE_DELAY_RESET;
            long_delay_reg    <= LONG_DELAY_RESET;
            press_ticks_reg   <= '0;
            release_ticks_reg <= COUNT_MAX;
            recent_keys_reg   <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr)
                    ADDR_SINGLE_DELAY: single_delay_reg <= pwdata[COUNT_W-1:0];
                    ADDR_LONG_DELAY:   long_delay_reg   <= pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                press_ticks_reg   <= press_ticks_next;
                release_ticks_reg <= release_ticks_next;
                recent_keys_reg   <= recent_keys_next;
            end

            if (out_valid_reg && m_ready) begin
                // drain: refill from skid first, else from the new tick
                if (skid_valid_reg) begin
                    out_kind_reg   <= skid_kind_reg;
                    out_key_reg    <= skid_key_reg;
                    skid_valid_reg <= 1'b0;
                end else if (accept && fire) begin
                    out_kind_reg <= kind;
                    out_key_reg  <= recent_keys_next[KEY_W-1:0];
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg) begin
                if (accept && fire) begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= kind;
                    out_key_reg   <= recent_keys_next[KEY_W-1:0];
                end
            end else if (accept && fire) begin
                // output stalled: park the new click in the skid entry
                skid_valid_reg <= 1'b1;
                skid_kind_reg  <= kind;
                skid_key_reg   <= recent_keys_next[KEY_W-1:0];
            end
        end
    end

    `KCC_ASSERT_NOW(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry occupied while output register is empty")
    `KCC_ASSERT_NEXT(a_stall_parks, aclk, aresetn,
        (out_valid_reg && !m_ready && accept && fire), skid_valid_reg,
        "click taken during output stall was not parked")
    `KCC_ASSERT_NEXT(a_skid_drains, aclk, aresetn,
        (out_valid_reg && m_ready && skid_valid_reg), (out_valid_reg && !skid_valid_reg),
        "skid entry did not move into the output register")
    `KCC_ASSERT_NOW(a_kind_legal, aclk, aresetn, out_valid_reg,
        (out_kind_reg == KIND_SINGLE || out_kind_reg == KIND_DOUBLE ||
         out_kind_reg == KIND_LONG),
        "illegal click kind on output")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_click_classifier_core: scan ticks in, clicks checked.
module tb_top;
    import kcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
    localparam int SETTLE_CYCLES  = 4;     // margin after the last predicted click is out
    localparam int MAX_REPORTS    = 10;
    localparam int LONG_HOLD      = 150;   // receiver hold-off used to back up the core

    typedef struct packed {
        kcc_kind_t         kind;
        logic [KEY_W-1:0]  key;
    } click_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [KEY_W-1:0]    s_key;
    logic                m_valid;
    logic                m_ready;
    logic [KIND_W-1:0]   m_click_kind;
    logic [KEY_W-1:0]    m_click_key;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Click model state: counters, key history and delay settings.
    logic [COUNT_W-1:0]  press_run;
    logic [COUNT_W-1:0]  release_run;
    logic [2*KEY_W-1:0]  key_hist;
    logic [COUNT_W-1:0]  single_delay;
    logic [COUNT_W-1:0]  long_delay;

    click_t expected_clicks[$];
    int     mismatch_cnt = 0;
    int     ticks_sent   = 0;
    int     idle_cycles  = 0;
    int     rx_hold_req  = 0;
    bit     tx_calm      = 1'b0;
    bit     rx_calm      = 1'b0;

    key_click_classifier_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key        (s_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_click_kind (m_click_kind),
        .m_click_key  (m_click_key),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the click model by one scan tick; return 1 when the tick yields a click.
    function automatic bit classify_tick(input logic [KEY_W-1:0] k, output click_t c);
        logic [COUNT_W-1:0] after_single;
        bit                 fire;
        bit                 settled;
        after_single = single_delay + 8'd1;   // wraps to 0 for a delay of 255
        fire    = 1'b0;
        settled = 1'b0;
        c.kind  = KIND_SINGLE;
        if (k == '0) begin
            if (release_run == single_delay) begin
                fire   = 1'b1;
                c.kind = KIND_SINGLE;
            end
            if (release_run > RELEASE_CLEAR_MIN)
                press_run = '0;
            if (release_run != COUNT_MAX)
                release_run = release_run + 8'd1;
        end else begin
            if (press_run == long_delay) begin
                fire        = 1'b1;
                c.kind      = KIND_LONG;
                release_run = after_single;
            end
            // Latch the key once the press is debounced; a quick second press
            // makes a double click, downgraded to single when the keys differ.
            // This decision overrides a long click flagged on the same tick.
            if (press_run == PRESS_SHIFT_TICK) begin
                key_hist = {key_hist[KEY_W-1:0], k};
                if (release_run < single_delay) begin
                    fire   = 1'b1;
                    c.kind = (key_hist[2*KEY_W-1:KEY_W] == key_hist[KEY_W-1:0]) ?
                             KIND_DOUBLE : KIND_SINGLE;
                    release_run = after_single;
                    press_run   = long_delay + 8'd1;
                    settled     = 1'b1;
                end else begin
                    release_run = '0;
                end
            end
            if (!settled && press_run != COUNT_MAX)
                press_run = press_run + 8'd1;
        end
        c.key = key_hist[KEY_W-1:0];
        return fire;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Scoreboard and watchdog: predict on every accepted tick, compare every
    // accepted click with the oldest prediction, and bail out if traffic stops.
    always @(posedge aclk) begin : scoreboard
        click_t want;
        click_t got;
        bit     moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                moved = 1'b1;
                if (classify_tick(s_key, want))
                    expected_clicks.push_back(want);
            end
            if (m_valid && m_ready) begin
                moved    = 1'b1;
                got.kind = kcc_kind_t'(m_click_kind);
                got.key  = m_click_key;
                if (expected_clicks.size() == 0) begin
                    note_mismatch($sformatf("unexpected click kind %0d key %0d",
                                            m_click_kind, m_click_key));
                end else begin
                    want = expected_clicks.pop_front();
                    if (got.kind !== want.kind)
                        note_mismatch($sformatf("click_kind expected %0d got %0d",
                                                want.kind, m_click_kind));
                    if (got.key !== want.key)
                        note_mismatch($sformatf("click_key expected %0d got %0d",
                                                want.key, m_click_key));
                end
            end
            if (psel && penable && pready)
                moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: random stall bursts, an optional long hold-off, none when calm.
    initial begin : rx_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one scan tick, sometimes after an idle burst; return at the falling
    // edge after it is accepted, with valid still high.
    task automatic send_tick(input logic [KEY_W-1:0] k);
        if (!tx_calm && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            s_key   <= KEY_W'($urandom_range(0, 15));
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_key   <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic send_run(input logic [KEY_W-1:0] k, input int n);
        repeat (n) send_tick(k);
    endtask

    // Drop valid and hold until every predicted click has come out.
    task automatic drain_clicks();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_clicks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input kcc_addr_t a, input logic [COUNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= DATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (a == ADDR_SINGLE_DELAY)
            single_delay = v;
        else
            long_delay = v;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read(input kcc_addr_t a);
        logic [COUNT_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        want = (a == ADDR_SINGLE_DELAY) ? single_delay : long_delay;
        if (prdata !== DATA_W'(want))
            note_mismatch($sformatf("register %0d read expected %0d got %0d",
                                    a, want, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram both delays on an idle core and read them back.
    task automatic set_delays(input logic [COUNT_W-1:0] s, input logic [COUNT_W-1:0] l);
        drain_clicks();
        cfg_write(ADDR_SINGLE_DELAY, s);
        cfg_write(ADDR_LONG_DELAY, l);
        cfg_read(ADDR_SINGLE_DELAY);
        cfg_read(ADDR_LONG_DELAY);
    endtask

    // Mostly real keys 1..10, sometimes the codes above the keypad range.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return KEY_W'($urandom_range(11, 15));
        return KEY_W'($urandom_range(1, 10));
    endfunction

    // One user gesture with random content: tap, double tap, hold, bounce or noise.
    task automatic play_gesture();
        int               press_cap;
        int               rel_cap;
        int               gap_cap;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] k2;
        press_cap = (int'(long_delay) + 2 < 30) ? int'(long_delay) + 2 : 30;
        rel_cap   = (int'(single_delay) + 2 < 30) ? int'(single_delay) + 2 : 30;
        gap_cap   = (int'(single_delay) + 1 < 8) ? int'(single_delay) + 1 : 8;
        k  = pick_key();
        k2 = ($urandom_range(0, 3) == 0) ? pick_key() : k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                send_run(k, $urandom_range(1, press_cap));
                send_run('0, $urandom_range(1, rel_cap));
            end
            4, 5, 6: begin
                send_run(k, $urandom_range(2, 4));
                send_run('0, $urandom_range(1, gap_cap));
                send_run(k2, $urandom_range(2, 5));
                send_run('0, $urandom_range(1, rel_cap));
            end
            7: begin
                if (long_delay <= 40)
                    send_run(k, $urandom_range(int'(long_delay) + 1, int'(long_delay) + 4));
                else
                    send_run(k, press_cap);
                send_run('0, $urandom_range(1, rel_cap));
            end
            8: begin
                repeat ($urandom_range(1, 8)) send_tick(KEY_W'($urandom_range(0, 15)));
            end
            default: begin
                send_run(k, $urandom_range(1, 3));
                send_run(k2, $urandom_range(1, 3));
                send_run('0, $urandom_range(1, 3));
            end
        endcase
    endtask

    // Play gestures until n more ticks went in; now and then pause the sender
    // until every click is out.
    task automatic run_gestures(input int n);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < n) begin
            play_gesture();
            if (!tx_calm && $urandom_range(0, 39) == 0)
                drain_clicks();
        end
    endtask

    // Registers come up at their defaults; idle and short presses fire nothing.
    task automatic test_reset_state();
        cfg_read(ADDR_SINGLE_DELAY);
        cfg_read(ADDR_LONG_DELAY);
        send_run('0, 6);
        send_run(4'd7, 2);
        send_run('0, 4);
    endtask

    // One of each click: single, double on one key, double on two keys, long.
    task automatic test_click_kinds();
        set_delays(8'd6, 8'd5);
        send_run(4'd9, 3);        // single: press, then release past the delay
        send_run('0, 7);
        send_run(4'd15, 3);       // double on the same key
        send_run('0, 5);
        send_run(4'd15, 3);
        send_run('0, 1);
        send_run(4'd1, 3);        // double on two keys reports as single
        send_run('0, 5);
        send_run(4'd10, 3);
        send_run('0, 1);
        send_run(4'd8, 7);        // long hold
        send_run('0, 2);
    endtask

    // Delay plus one wrapping to zero, and long and double landing on one tick.
    task automatic test_delay_wrap();
        set_delays(8'd255, 8'd2);
        send_run('0, 5);
        send_run(4'd12, 4);
        send_run('0, 4);
        send_run(4'd12, 4);
        send_run('0, 4);
        run_gestures(10);
        set_delays(8'd3, 8'd255);
        run_gestures(10);
    endtask

    // Hold the result side off long enough that the core backs up and stalls
    // its input, then let the sender wait for the backlog.
    task automatic test_backpressure();
        set_delays(8'd6, 8'd3);
        tx_calm     = 1'b1;
        rx_hold_req = LONG_HOLD;
        run_gestures(40);
        tx_calm = 1'b0;
        drain_clicks();
    endtask

    // Random gestures over several delay settings, the extremes among them.
    task automatic test_random_phases();
        logic [KEY_W-1:0] k;
        set_delays(8'd3, 8'd3);
        run_gestures(20);

        set_delays(8'd3, 8'd254);
        k = pick_key();
        send_run('0, 6);          // clear the press count first
        send_run(k, 257);
        send_run('0, 6);
        run_gestures(10);

        set_delays(8'd254, 8'd3);
        k = pick_key();
        send_run('0, 6);
        send_run(k, 5);           // leaves the release count saturated
        send_run('0, 6);
        send_run(k, 3);
        send_run('0, 256);
        run_gestures(10);

        repeat (3) begin
            set_delays(COUNT_W'($urandom_range(3, 12)), COUNT_W'($urandom_range(3, 12)));
            run_gestures(12);
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_stream();
        set_delays(COUNT_W'($urandom_range(6, 10)), COUNT_W'($urandom_range(3, 8)));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_gestures(30);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_key        = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        press_run    = '0;
        release_run  = COUNT_MAX;
        key_hist     = '0;
        single_delay = SINGLE_DELAY_RESET;
        long_delay   = LONG_DELAY_RESET;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_click_kinds();
        test_delay_wrap();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        drain_clicks();
        if (mismatch_cnt == 0 && expected_clicks.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
